/* hdl/sorted_list_insert_unit_defines.svh */
// Assertion macros used by the checker of the sorted list insert unit.
// Both expect clk and arst_n in the scope where they are used.
`ifndef SORTED_LIST_INSERT_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLINS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLINS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/slins_pkg.sv */
`default_nettype none
package slins_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int VALUE_W        = 32;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;

	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_ENTRY   = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_RESTART,
		CMD_APPEND,
		CMD_INSERT,
		CMD_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t                   cmd;
		logic signed [VALUE_W-1:0]   value;
	} cell_ctl_t;

endpackage
`default_nettype wire

/* hdl/slins_item_if.sv */
`default_nettype none
interface slins_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           operation;
	logic signed [slins_pkg::VALUE_W-1:0] value;
	logic                                 first_item;

	modport source (output valid, output operation, output value, output first_item,
		input ready);
	modport sink (input valid, input operation, input value, input first_item,
		output ready);
endinterface
`default_nettype wire

/* hdl/slins_result_if.sv */
`default_nettype none
interface slins_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [slins_pkg::VALUE_W-1:0] entry_value;
	logic [1:0]                           status;
	logic                                 last;

	modport source (output valid, output entry_value, output status, output last,
		input ready);
	modport sink (input valid, input entry_value, input status, input last,
		output ready);
endinterface
`default_nettype wire

/* hdl/slins_cell.sv */
`default_nettype none
module slins_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  wire logic                                 clk,
	input  wire slins_pkg::cell_ctl_t                 ctl,
	input  wire logic [CNT_W-1:0]                     count,
	input  wire logic                                 prev_take,
	input  wire logic signed [slins_pkg::VALUE_W-1:0] prev_entry,
	input  wire logic signed [slins_pkg::VALUE_W-1:0] next_entry,
	input  wire logic signed [slins_pkg::VALUE_W-1:0] wrap_entry,
	output logic                                      take,
	output logic signed [slins_pkg::VALUE_W-1:0]      entry
);

	logic signed [slins_pkg::VALUE_W-1:0] entry_q;
	logic                                 beyond;
	logic                                 local_stop;

	assign entry  = entry_q;
	assign beyond = (count <= CNT_W'(INDEX));

	// head goes behind an equal value; later cells stop at the first entry not below it
	always_comb begin
		if (INDEX == 0) begin
			local_stop = (ctl.value < entry_q);
		end else begin
			local_stop = !(entry_q < ctl.value);
		end
		take = prev_take || beyond || local_stop;
	end

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			slins_pkg::CMD_HOLD: begin
			end
			slins_pkg::CMD_RESTART: begin
				if (INDEX == 0) begin
					entry_q <= ctl.value;
				end
			end
			slins_pkg::CMD_APPEND: begin
				if (count == CNT_W'(INDEX)) begin
					entry_q <= ctl.value;
				end
			end
			slins_pkg::CMD_INSERT: begin
				if (prev_take) begin
					entry_q <= prev_entry;
				end else if (take) begin
					entry_q <= ctl.value;
				end
			end
			slins_pkg::CMD_ROTATE: begin
				if (CNT_W'(INDEX + 1) < count) begin
					entry_q <= next_entry;
				end else if (CNT_W'(INDEX + 1) == count) begin
					entry_q <= wrap_entry;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* hdl/sorted_list_insert_unit.sv */
// Sorted list insert unit: a bounded list of signed 32-bit values held in a
// row of compare-and-shift cells.
// Channels: item (operation, value, first_item) in, result (entry_value,
// status, last) out, both valid/ready; a beat moves when both are high.
// Load and insert results are registered and show in the cycle after the
// item beat. Insert compares the value in every cell at once and each cell
// passes its decision to its neighbour, so the list shifts in the same
// cycle. Operation code 3 is taken and gives no result.
// Dump streams one entry per cycle from the head by rotating the row, while
// the result register is free or emptied in the same cycle; no item is taken
// while it runs. An empty list gives one beat with status empty.
// A new item is taken while a finished result waits, as long as the result
// register is free or emptied in the same cycle; a stalled result holds.
// Reset empties the list and the result register; cell contents need no
// clearing. Loads and inserts sustain one per cycle while results are taken.
`default_nettype none
module sorted_list_insert_unit #(
	parameter int LIST_DEPTH = slins_pkg::LIST_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	slins_item_if.sink    item,
	slins_result_if.source result
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	logic [CNT_W-1:0]                     count_q;
	logic [CNT_W-1:0]                     remain_q;
	logic                                 dump_q;
	logic                                 out_valid_q;
	logic signed [slins_pkg::VALUE_W-1:0] out_value_q;
	logic [1:0]                           out_status_q;
	logic                                 out_last_q;

	logic                                 out_free;
	logic                                 accept;
	logic                                 step;
	logic                                 full;
	slins_pkg::cell_ctl_t                 ctl;

	logic                                 take_w  [LIST_DEPTH];
	logic signed [slins_pkg::VALUE_W-1:0] entry_w [LIST_DEPTH];

	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = !dump_q && out_free;
	assign accept     = item.valid && item.ready;
	assign step       = dump_q && out_free;
	assign full       = (count_q == CNT_W'(LIST_DEPTH));

	assign result.valid       = out_valid_q;
	assign result.entry_value = out_value_q;
	assign result.status      = out_status_q;
	assign result.last        = out_last_q;

	always_comb begin
		ctl.value = item.value;
		ctl.cmd   = slins_pkg::CMD_HOLD;
		if (step) begin
			ctl.cmd = slins_pkg::CMD_ROTATE;
		end else if (accept) begin
			priority if (item.operation == slins_pkg::OP_LOAD && item.first_item) begin
				ctl.cmd = slins_pkg::CMD_RESTART;
			end else if (item.operation == slins_pkg::OP_LOAD && !full) begin
				ctl.cmd = slins_pkg::CMD_APPEND;
			end else if (item.operation == slins_pkg::OP_INSERT && !full) begin
				ctl.cmd = slins_pkg::CMD_INSERT;
			end else begin
				ctl.cmd = slins_pkg::CMD_HOLD;
			end
		end
	end

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic                                 prev_take;
		logic signed [slins_pkg::VALUE_W-1:0] prev_entry;
		logic signed [slins_pkg::VALUE_W-1:0] next_entry;

		if (i == 0) begin : g_head
			assign prev_take  = 1'b0;
			assign prev_entry = '0;
		end else begin : g_body
			assign prev_take  = take_w[i-1];
			assign prev_entry = entry_w[i-1];
		end

		if (i == LIST_DEPTH - 1) begin : g_tail
			assign next_entry = entry_w[0];
		end else begin : g_inner
			assign next_entry = entry_w[i+1];
		end

		slins_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.prev_take  (prev_take),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.wrap_entry (entry_w[0]),
			.take       (take_w[i]),
			.entry      (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			remain_q    <= '0;
			dump_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
				remain_q    <= remain_q - CNT_W'(1);
				if (remain_q == CNT_W'(1)) begin
					dump_q <= 1'b0;
				end
			end else if (accept) begin
				unique case (item.operation)
					slins_pkg::OP_LOAD: begin
						out_valid_q <= 1'b1;
						if (item.first_item) begin
							count_q <= CNT_W'(1);
						end else if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					slins_pkg::OP_INSERT: begin
						out_valid_q <= 1'b1;
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					slins_pkg::OP_DUMP: begin
						if (count_q == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							dump_q   <= 1'b1;
							remain_q <= count_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_value_q  <= entry_w[0];
			out_status_q <= slins_pkg::ST_ENTRY;
			out_last_q   <= (remain_q == CNT_W'(1));
		end else if (accept) begin
			out_value_q <= '0;
			out_last_q  <= 1'b1;
			if (item.operation == slins_pkg::OP_DUMP) begin
				out_status_q <= slins_pkg::ST_EMPTY;
			end else if (full && !(item.operation == slins_pkg::OP_LOAD && item.first_item)) begin
				out_status_q <= slins_pkg::ST_DROPPED;
			end else begin
				out_status_q <= slins_pkg::ST_STORED;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/slins_checker.sv */
`default_nettype none
`include "sorted_list_insert_unit_defines.svh"
module slins_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 item_valid,
	input wire logic                                 item_ready,
	input wire logic [1:0]                           item_operation,
	input wire logic                                 result_valid,
	input wire logic                                 result_ready,
	input wire logic signed [slins_pkg::VALUE_W-1:0] result_entry_value,
	input wire logic [1:0]                           result_status,
	input wire logic                                 result_last
);

	`SLINS_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid, "result beat dropped while stalled")
	`SLINS_ASSERT_NEXT(a_load_answers, item_valid && item_ready && item_operation == slins_pkg::OP_LOAD, result_valid && result_last && result_entry_value == '0 && (result_status == slins_pkg::ST_STORED || result_status == slins_pkg::ST_DROPPED), "load beat gave no single stored or dropped result")
	`SLINS_ASSERT_NOW(a_dump_blocks, result_valid && result_status == slins_pkg::ST_ENTRY && !result_last, !item_ready, "item taken in the middle of a dump")
	`SLINS_ASSERT_NOW(a_single_result, result_valid && result_status != slins_pkg::ST_ENTRY, result_last && result_entry_value == '0, "non-entry result not a lone zero beat")

endmodule

bind sorted_list_insert_unit slins_checker u_slins_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.item_operation     (item.operation),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_entry_value (result.entry_value),
	.result_status      (result.status),
	.result_last        (result.last)
);
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;

	localparam int DEPTH = slins_pkg::LIST_DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic signed [slins_pkg::VALUE_W-1:0] entry_value;
		logic [1:0]                           status;
		logic                                 last;
	} list_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	slins_item_if   item_ch ();
	slins_result_if result_ch ();

	sorted_list_insert_unit #(.LIST_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	logic signed [slins_pkg::VALUE_W-1:0] shadow_list [DEPTH];
	int                                   shadow_len = 0;
	list_beat_t                           expected_beats [$];
	int                                   error_count = 0;
	int                                   src_idle_pct = 0;
	int                                   snk_idle_pct = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void push_beat(input logic signed [slins_pkg::VALUE_W-1:0] val,
			input logic [1:0] st, input logic is_last);
		list_beat_t b;
		b.entry_value = val;
		b.status      = st;
		b.last        = is_last;
		expected_beats.push_back(b);
	endfunction

	// Update the shadow list for one accepted beat and queue what it produces.
	function automatic void apply_list_op(input logic [1:0] op,
			input logic signed [slins_pkg::VALUE_W-1:0] val, input logic first);
		int pos;
		case (op)
		slins_pkg::OP_LOAD: begin
			if (first) begin
				shadow_list[0] = val;
				shadow_len = 1;
				push_beat('0, slins_pkg::ST_STORED, 1'b1);
			end else if (shadow_len >= DEPTH) begin
				push_beat('0, slins_pkg::ST_DROPPED, 1'b1);
			end else begin
				shadow_list[shadow_len] = val;
				shadow_len++;
				push_beat('0, slins_pkg::ST_STORED, 1'b1);
			end
		end
		slins_pkg::OP_INSERT: begin
			if (shadow_len >= DEPTH) begin
				push_beat('0, slins_pkg::ST_DROPPED, 1'b1);
			end else begin
				if (shadow_len == 0 || val < shadow_list[0]) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < shadow_len && shadow_list[pos] < val)
						pos++;
				end
				for (int i = shadow_len; i > pos; i--)
					shadow_list[i] = shadow_list[i-1];
				shadow_list[pos] = val;
				shadow_len++;
				push_beat('0, slins_pkg::ST_STORED, 1'b1);
			end
		end
		slins_pkg::OP_DUMP: begin
			if (shadow_len == 0) begin
				push_beat('0, slins_pkg::ST_EMPTY, 1'b1);
			end else begin
				for (int i = 0; i < shadow_len; i++)
					push_beat(shadow_list[i], slins_pkg::ST_ENTRY, (i == shadow_len - 1));
			end
		end
		default: ;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op,
			input logic signed [slins_pkg::VALUE_W-1:0] val, input logic first);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.operation  <= op;
		item_ch.value      <= val;
		item_ch.first_item <= first;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		apply_list_op(op, val, first);
	endtask

	// Hold the sender until every queued beat has come back.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [slins_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'sh8000_0000;
		1: return 32'sh7fff_ffff;
		2, 3, 4: return int'($urandom_range(0, 8)) - 4;
		default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		send_item(slins_pkg::OP_DUMP, '0, 1'b0);
		send_item(OP_NONE, 32'shffff_ffff, 1'b1);
		send_item(slins_pkg::OP_INSERT, 32'sh7fff_ffff, 1'b1);
		send_item(slins_pkg::OP_INSERT, 32'sh8000_0000, 1'b0);
		send_item(slins_pkg::OP_INSERT, 32'sh8000_0000, 1'b0);
		send_item(slins_pkg::OP_DUMP, 32'sh5555_5555, 1'b1);
	endtask

	task automatic test_full_list();
		for (int k = 1; k <= DEPTH - 3; k++)
			send_item(slins_pkg::OP_LOAD, (k % 2) ? -k * 1000 : k * 77, 1'b0);
		send_item(slins_pkg::OP_LOAD, 32'sh8000_0000, 1'b0);
		send_item(slins_pkg::OP_INSERT, 32'sh0000_0000, 1'b1);
		send_item(slins_pkg::OP_DUMP, '0, 1'b0);
		send_item(slins_pkg::OP_LOAD, 32'shaaaa_aaaa, 1'b1);
		send_item(slins_pkg::OP_DUMP, '0, 1'b0);
	endtask

	task automatic test_random_mix(input int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_item(slins_pkg::OP_LOAD, pick_value(), 1'b1);
			else if (r < 30)
				send_item(slins_pkg::OP_LOAD, pick_value(), 1'b0);
			else if (r < 75)
				send_item(slins_pkg::OP_INSERT, pick_value(), 1'($urandom_range(0, 1)));
			else if (r < 93)
				send_item(slins_pkg::OP_DUMP, $urandom, 1'($urandom_range(0, 1)));
			else
				send_item(OP_NONE, $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	always @(posedge clk) begin : check_beats
		list_beat_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: value %0d status %0d last %0b",
					result_ch.entry_value, result_ch.status, result_ch.last));
			end else begin
				want = expected_beats.pop_front();
				if (result_ch.entry_value !== want.entry_value || result_ch.status !== want.status
						|| result_ch.last !== want.last)
					report_mismatch($sformatf(
						"beat mismatch: got value %0d status %0d last %0b, want %0d %0d %0b",
						result_ch.entry_value, result_ch.status, result_ch.last,
						want.entry_value, want.status, want.last));
			end
		end
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("Timeout: no beat for %0d cycles", STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.operation  = slins_pkg::OP_LOAD;
		item_ch.value      = '0;
		item_ch.first_item = 1'b0;
		src_idle_pct       = 32;
		snk_idle_pct       = 70;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_full_list();
		test_random_mix(60);
		wait_drained();

		src_idle_pct = 70;
		snk_idle_pct = 32;
		test_random_mix(65);
		wait_drained();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_mix(60);
		wait_drained();

		repeat (DEPTH + 8) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
